// ===== hdl/convex_hull_support_query_top_assert.svh =====
// Assertion helpers, clocked on clk and held off while arst_n is low.
`ifndef CONVEX_HULL_SUPPORT_QUERY_TOP_ASSERT_SVH
`define CONVEX_HULL_SUPPORT_QUERY_TOP_ASSERT_SVH

// Same-cycle implication.
`define CHSQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CHSQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/chsq_pkg.sv =====
`timescale 1ns / 1ps

package chsq_pkg;

	localparam int MAX_VERTICES = 32;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int CNT_W        = VIDX_W + 1;

	localparam int COORD_W   = 32;
	localparam int QUAT_W    = 16;
	localparam int Q_W       = QUAT_W + 1;
	localparam int T_W       = 36;
	localparam int MUL_A_W   = 36;
	localparam int MUL_B_W   = 33;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;
	localparam int ACC_W     = 56;
	localparam int DOT_W     = 50;
	localparam int SAT_W     = 44;
	localparam int SUM_W     = 37;
	localparam int MAG_W     = 49;
	localparam int MPROD_W   = 65;
	localparam int MARGIN_W  = 34;
	localparam int THR_W     = 51;
	localparam int CFG_IDX_W = 3;

	localparam int TIE_SCALE = 42950;
	localparam int ONE_Q16   = 65536;

	localparam logic [3:0] ROT_LAST_STEP = 4'd14;

	localparam logic [1:0] KIND_LOAD    = 2'd0;
	localparam logic [1:0] KIND_SUPPORT = 2'd1;
	localparam logic [1:0] KIND_BOX     = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_W       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_X       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 3'd7;

	// quaternion component select
	localparam logic [1:0] QS_W = 2'd0;
	localparam logic [1:0] QS_X = 2'd1;
	localparam logic [1:0] QS_Y = 2'd2;
	localparam logic [1:0] QS_Z = 2'd3;

	// vector operand select: bit 2 picks the cross-product temp over the input vector
	localparam logic [2:0] OP_V0 = 3'b000;
	localparam logic [2:0] OP_V1 = 3'b001;
	localparam logic [2:0] OP_V2 = 3'b010;
	localparam logic [2:0] OP_T0 = 3'b100;
	localparam logic [2:0] OP_T1 = 3'b101;
	localparam logic [2:0] OP_T2 = 3'b110;

	typedef struct packed {
		logic [1:0] qsel;
		logic [2:0] osel;
		logic       neg;
		logic       last;
		logic [1:0] dst;
		logic       to_r;
	} rot_op_t;

	// Microprogram of one quaternion rotation: 15 multiply-accumulates.
	function automatic rot_op_t rot_op(input logic [3:0] step);
		rot_op_t op;
		case (step)
			4'd0:    op = '{QS_Y, OP_V2, 1'b0, 1'b0, 2'd0, 1'b0};
			4'd1:    op = '{QS_Z, OP_V1, 1'b1, 1'b1, 2'd0, 1'b0};
			4'd2:    op = '{QS_Z, OP_V0, 1'b0, 1'b0, 2'd1, 1'b0};
			4'd3:    op = '{QS_X, OP_V2, 1'b1, 1'b1, 2'd1, 1'b0};
			4'd4:    op = '{QS_X, OP_V1, 1'b0, 1'b0, 2'd2, 1'b0};
			4'd5:    op = '{QS_Y, OP_V0, 1'b1, 1'b1, 2'd2, 1'b0};
			4'd6:    op = '{QS_W, OP_T0, 1'b0, 1'b0, 2'd0, 1'b1};
			4'd7:    op = '{QS_Y, OP_T2, 1'b0, 1'b0, 2'd0, 1'b1};
			4'd8:    op = '{QS_Z, OP_T1, 1'b1, 1'b1, 2'd0, 1'b1};
			4'd9:    op = '{QS_W, OP_T1, 1'b0, 1'b0, 2'd1, 1'b1};
			4'd10:   op = '{QS_Z, OP_T0, 1'b0, 1'b0, 2'd1, 1'b1};
			4'd11:   op = '{QS_X, OP_T2, 1'b1, 1'b1, 2'd1, 1'b1};
			4'd12:   op = '{QS_W, OP_T2, 1'b0, 1'b0, 2'd2, 1'b1};
			4'd13:   op = '{QS_X, OP_T1, 1'b0, 1'b0, 2'd2, 1'b1};
			4'd14:   op = '{QS_Y, OP_T0, 1'b1, 1'b1, 2'd2, 1'b1};
			default: op = '{QS_W, OP_V0, 1'b0, 1'b1, 2'd0, 1'b1};
		endcase
		return op;
	endfunction

	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SAT_W-1:0] x);
		logic [SAT_W-COORD_W:0] top;
		top = x[SAT_W-1:COORD_W-1];
		if (top == '0 || top == '1) begin
			return x[COORD_W-1:0];
		end
		return x[SAT_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
	endfunction

endpackage

// ===== hdl/convex_hull_support_query_top.sv =====
// Load request: no result. Unused kind is dropped.
// Support query: runs on one shared
//   36x33 multiplier (two 15-step rotations, 3 products per vertex) and a
//   37-step restoring divider run once per axis.
// One request at a time; a new request is taken once the previous one finishes.
// Async reset sets centre 0, identity quaternion, count 0; vertex memory is not cleared.
`timescale 1ns / 1ps

`include "convex_hull_support_query_top_assert.svh"

module convex_hull_support_query_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [chsq_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [chsq_pkg::COORD_W-1:0]           cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [1:0]                             kind,
	input  logic [4:0]                             slot,
	input  logic signed [chsq_pkg::COORD_W-1:0]    coord_x,
	input  logic signed [chsq_pkg::COORD_W-1:0]    coord_y,
	input  logic signed [chsq_pkg::COORD_W-1:0]    coord_z,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [chsq_pkg::COORD_W-1:0]    point_x,
	output logic signed [chsq_pkg::COORD_W-1:0]    point_y,
	output logic signed [chsq_pkg::COORD_W-1:0]    point_z,
	output logic                                   last_result
);

	localparam logic [4:0] S_IDLE      = 5'd0;
	localparam logic [4:0] S_ROT       = 5'd1;
	localparam logic [4:0] S_DOT_RD    = 5'd2;
	localparam logic [4:0] S_DOT_MUL   = 5'd3;
	localparam logic [4:0] S_DOT_NEXT  = 5'd4;
	localparam logic [4:0] S_MAG       = 5'd5;
	localparam logic [4:0] S_MPROD     = 5'd6;
	localparam logic [4:0] S_THRESH    = 5'd7;
	localparam logic [4:0] S_TIE_RD    = 5'd8;
	localparam logic [4:0] S_TIE_ACC   = 5'd9;
	localparam logic [4:0] S_DIV_INIT  = 5'd10;
	localparam logic [4:0] S_DIV       = 5'd11;
	localparam logic [4:0] S_SUP_FIN   = 5'd12;
	localparam logic [4:0] S_BOX_RD    = 5'd13;
	localparam logic [4:0] S_BOX_LD    = 5'd14;
	localparam logic [4:0] S_BOX_WORLD = 5'd15;
	localparam logic [4:0] S_BOX_UPD   = 5'd16;
	localparam logic [4:0] S_EMIT_LO   = 5'd17;
	localparam logic [4:0] S_EMIT_HI   = 5'd18;

	localparam int CW  = chsq_pkg::COORD_W;
	localparam int VW  = chsq_pkg::VIDX_W;
	localparam int NW  = chsq_pkg::CNT_W;

	// control
	logic [4:0]    state_q, ret_q;
	logic [3:0]    mstep_q;
	logic [1:0]    phase_q;
	logic [1:0]    comp_q;
	logic          conj_q;
	logic [NW-1:0] idx_q;
	logic [5:0]    bitc_q;
	logic          out_valid_q;

	// configuration
	logic signed [CW-1:0]                   center_q [3];
	logic signed [chsq_pkg::QUAT_W-1:0]     quat_w_q, quat_x_q, quat_y_q, quat_z_q;
	logic [5:0]                             vcount_q;

	// storage
	logic signed [CW-1:0]               vx_mem [chsq_pkg::MAX_VERTICES];
	logic signed [CW-1:0]               vy_mem [chsq_pkg::MAX_VERTICES];
	logic signed [CW-1:0]               vz_mem [chsq_pkg::MAX_VERTICES];
	logic signed [chsq_pkg::DOT_W-1:0]  dot_mem [chsq_pkg::MAX_VERTICES];
	logic signed [CW-1:0]               vr_q [3];
	logic signed [chsq_pkg::DOT_W-1:0]  dot_rd_q;

	// datapath
	logic signed [CW-1:0]                   vv_q [3];
	logic signed [chsq_pkg::T_W-1:0]        t_q [3];
	logic signed [CW-1:0]                   r_q [3];
	logic signed [chsq_pkg::PROD_W-1:0]     prod_s1;
	logic signed [chsq_pkg::ACC_W-1:0]      acc_q;
	logic signed [chsq_pkg::DOT_W-1:0]      dot_q, best_q;
	logic [chsq_pkg::MAG_W-1:0]             mag_q;
	logic [chsq_pkg::MPROD_W-1:0]           mprod_q;
	logic signed [chsq_pkg::THR_W-1:0]      thresh_q;
	logic signed [chsq_pkg::SUM_W-1:0]      sum_q [3];
	logic [5:0]                             cnt_q;
	logic [chsq_pkg::SUM_W-1:0]             dq_q;
	logic [5:0]                             rem_q, divisor_q;
	logic                                   sneg_q;
	logic signed [CW-1:0]                   w_q [3], lo_q [3], hi_q [3];
	logic signed [CW-1:0]                   pt_x_q, pt_y_q, pt_z_q;
	logic                                   last_q;

	// combinational
	logic                                   in_acc, out_free, out_load, ld_we, dot_we;
	logic [NW-1:0]                          n_cnt;
	logic [NW-1:0]                          idx_inc;
	chsq_pkg::rot_op_t                      op;
	logic signed [chsq_pkg::Q_W-1:0]        q_val;
	logic signed [chsq_pkg::MUL_A_W-1:0]    mul_a;
	logic signed [chsq_pkg::MUL_B_W-1:0]    mul_b;
	logic signed [chsq_pkg::ACC_W-1:0]      rot_acc_nx, dot_acc_nx;
	logic signed [chsq_pkg::T_W-1:0]        t_new;
	logic signed [CW-1:0]                   r_new;
	logic signed [CW-1:0]                   world [3];
	logic [chsq_pkg::DOT_W-1:0]             best_abs;
	logic [chsq_pkg::MARGIN_W-1:0]          margin;
	logic                                   tie;
	logic [6:0]                             remsh, rem_sub;
	logic                                   qbit;
	logic [chsq_pkg::SUM_W-1:0]             quot;
	logic [chsq_pkg::SUM_W-1:0]             sum_abs;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign ld_we    = in_acc && (kind == chsq_pkg::KIND_LOAD)
		&& (32'(slot) < chsq_pkg::MAX_VERTICES);
	assign out_free = !out_valid_q || out_ready;
	assign out_load = ((state_q == S_EMIT_LO) || (state_q == S_EMIT_HI)) && out_free;
	assign dot_we   = (state_q == S_DOT_MUL) && (phase_q == 2'd1) && (comp_q == 2'd2);

	assign n_cnt   = (vcount_q > NW'(chsq_pkg::MAX_VERTICES)) ?
		NW'(chsq_pkg::MAX_VERTICES) : NW'(vcount_q);
	assign idx_inc = idx_q + NW'(1);

	assign op = chsq_pkg::rot_op(mstep_q);

	always_comb begin
		case (op.qsel)
			chsq_pkg::QS_W: q_val = chsq_pkg::Q_W'(quat_w_q);
			chsq_pkg::QS_X: q_val = conj_q ? -chsq_pkg::Q_W'(quat_x_q) : chsq_pkg::Q_W'(quat_x_q);
			chsq_pkg::QS_Y: q_val = conj_q ? -chsq_pkg::Q_W'(quat_y_q) : chsq_pkg::Q_W'(quat_y_q);
			default:        q_val = conj_q ? -chsq_pkg::Q_W'(quat_z_q) : chsq_pkg::Q_W'(quat_z_q);
		endcase
	end

	// one shared multiplier: rotation steps and dot-product terms
	always_comb begin
		if (state_q == S_DOT_MUL) begin
			mul_a = chsq_pkg::MUL_A_W'(vr_q[comp_q]);
			mul_b = chsq_pkg::MUL_B_W'(r_q[comp_q]);
		end else begin
			if (op.osel[2]) begin
				mul_a = chsq_pkg::MUL_A_W'(t_q[op.osel[1:0]]);
			end else begin
				mul_a = chsq_pkg::MUL_A_W'(vv_q[op.osel[1:0]]);
			end
			mul_b = chsq_pkg::MUL_B_W'(q_val);
		end
	end

	assign rot_acc_nx = op.neg ? acc_q - chsq_pkg::ACC_W'(prod_s1)
		: acc_q + chsq_pkg::ACC_W'(prod_s1);
	assign dot_acc_nx = acc_q + chsq_pkg::ACC_W'(prod_s1 >>> 16);
	assign t_new      = chsq_pkg::T_W'(acc_q >>> 13);
	assign r_new      = chsq_pkg::sat_coord(chsq_pkg::SAT_W'(acc_q >>> 14)
		+ chsq_pkg::SAT_W'(vv_q[op.dst]));

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			world[k] = chsq_pkg::sat_coord(chsq_pkg::SAT_W'(center_q[k])
				+ chsq_pkg::SAT_W'(r_q[k]));
		end
	end

	assign best_abs = best_q[chsq_pkg::DOT_W-1] ? -best_q : best_q;
	// ceil(mag * scale / 2^32)
	assign margin   = chsq_pkg::MARGIN_W'((mprod_q + chsq_pkg::MPROD_W'(32'hFFFF_FFFF)) >> 32);
	assign tie      = chsq_pkg::THR_W'(dot_rd_q) >= thresh_q;

	assign sum_abs = sum_q[comp_q][chsq_pkg::SUM_W-1] ? -sum_q[comp_q] : sum_q[comp_q];
	assign remsh   = {rem_q, dq_q[chsq_pkg::SUM_W-1]};
	assign qbit    = remsh >= {1'b0, divisor_q};
	assign rem_sub = qbit ? remsh - {1'b0, divisor_q} : remsh;
	assign quot    = {dq_q[chsq_pkg::SUM_W-2:0], qbit};

	// control and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			mstep_q     <= '0;
			phase_q     <= '0;
			comp_q      <= '0;
			conj_q      <= 1'b0;
			idx_q       <= '0;
			bitc_q      <= '0;
			out_valid_q <= 1'b0;
			center_q[0] <= '0;
			center_q[1] <= '0;
			center_q[2] <= '0;
			quat_w_q    <= 16'sd16384;
			quat_x_q    <= '0;
			quat_y_q    <= '0;
			quat_z_q    <= '0;
			vcount_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					chsq_pkg::REG_CENTER_X:     center_q[0] <= cfg_data;
					chsq_pkg::REG_CENTER_Y:     center_q[1] <= cfg_data;
					chsq_pkg::REG_CENTER_Z:     center_q[2] <= cfg_data;
					chsq_pkg::REG_QUAT_W:       quat_w_q    <= cfg_data[15:0];
					chsq_pkg::REG_QUAT_X:       quat_x_q    <= cfg_data[15:0];
					chsq_pkg::REG_QUAT_Y:       quat_y_q    <= cfg_data[15:0];
					chsq_pkg::REG_QUAT_Z:       quat_z_q    <= cfg_data[15:0];
					chsq_pkg::REG_VERTEX_COUNT: vcount_q    <= cfg_data[5:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					idx_q   <= '0;
					comp_q  <= '0;
					mstep_q <= '0;
					phase_q <= '0;
					if (in_acc) begin
						case (kind)
							chsq_pkg::KIND_SUPPORT: begin
								if (n_cnt == '0) begin
									state_q <= S_EMIT_HI;
								end else begin
									conj_q  <= 1'b1;
									ret_q   <= S_DOT_RD;
									state_q <= S_ROT;
								end
							end
							chsq_pkg::KIND_BOX: begin
								state_q <= (n_cnt == '0) ? S_EMIT_LO : S_BOX_RD;
							end
							default: ;
						endcase
					end
				end
				S_ROT: begin
					case (phase_q)
						2'd0: phase_q <= 2'd1;
						2'd1: begin
							if (op.last) begin
								phase_q <= 2'd2;
							end else begin
								phase_q <= 2'd0;
								mstep_q <= mstep_q + 4'd1;
							end
						end
						default: begin
							phase_q <= 2'd0;
							if (mstep_q == chsq_pkg::ROT_LAST_STEP) begin
								mstep_q <= '0;
								state_q <= ret_q;
							end else begin
								mstep_q <= mstep_q + 4'd1;
							end
						end
					endcase
				end
				S_DOT_RD: begin
					phase_q <= '0;
					comp_q  <= '0;
					state_q <= S_DOT_MUL;
				end
				S_DOT_MUL: begin
					if (phase_q == 2'd0) begin
						phase_q <= 2'd1;
					end else begin
						phase_q <= 2'd0;
						if (comp_q == 2'd2) begin
							comp_q  <= '0;
							state_q <= S_DOT_NEXT;
						end else begin
							comp_q <= comp_q + 2'd1;
						end
					end
				end
				S_DOT_NEXT: begin
					if (idx_inc == n_cnt) begin
						state_q <= S_MAG;
					end else begin
						idx_q   <= idx_inc;
						state_q <= S_DOT_RD;
					end
				end
				S_MAG:    state_q <= S_MPROD;
				S_MPROD:  state_q <= S_THRESH;
				S_THRESH: begin
					idx_q   <= '0;
					state_q <= S_TIE_RD;
				end
				S_TIE_RD: state_q <= S_TIE_ACC;
				S_TIE_ACC: begin
					if (idx_inc == n_cnt) begin
						comp_q  <= '0;
						state_q <= S_DIV_INIT;
					end else begin
						idx_q   <= idx_inc;
						state_q <= S_TIE_RD;
					end
				end
				S_DIV_INIT: begin
					bitc_q  <= 6'(chsq_pkg::SUM_W);
					state_q <= S_DIV;
				end
				S_DIV: begin
					bitc_q <= bitc_q - 6'd1;
					if (bitc_q == 6'd1) begin
						if (comp_q == 2'd2) begin
							comp_q  <= '0;
							conj_q  <= 1'b0;
							mstep_q <= '0;
							phase_q <= '0;
							ret_q   <= S_SUP_FIN;
							state_q <= S_ROT;
						end else begin
							comp_q  <= comp_q + 2'd1;
							state_q <= S_DIV_INIT;
						end
					end
				end
				S_SUP_FIN: state_q <= S_EMIT_HI;
				S_BOX_RD:  state_q <= S_BOX_LD;
				S_BOX_LD: begin
					conj_q  <= 1'b0;
					mstep_q <= '0;
					phase_q <= '0;
					ret_q   <= S_BOX_WORLD;
					state_q <= S_ROT;
				end
				S_BOX_WORLD: state_q <= S_BOX_UPD;
				S_BOX_UPD: begin
					if (idx_inc == n_cnt) begin
						state_q <= S_EMIT_LO;
					end else begin
						idx_q   <= idx_inc;
						state_q <= S_BOX_RD;
					end
				end
				S_EMIT_LO: begin
					if (out_free) begin
						state_q <= S_EMIT_HI;
					end
				end
				S_EMIT_HI: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// vertex and dot memories, registered reads at the scan index
	always_ff @(posedge clk) begin
		if (ld_we) begin
			vx_mem[slot[VW-1:0]] <= coord_x;
			vy_mem[slot[VW-1:0]] <= coord_y;
			vz_mem[slot[VW-1:0]] <= coord_z;
		end
		if (dot_we) begin
			dot_mem[idx_q[VW-1:0]] <= chsq_pkg::DOT_W'(dot_acc_nx);
		end
		vr_q[0]  <= vx_mem[idx_q[VW-1:0]];
		vr_q[1]  <= vy_mem[idx_q[VW-1:0]];
		vr_q[2]  <= vz_mem[idx_q[VW-1:0]];
		dot_rd_q <= dot_mem[idx_q[VW-1:0]];
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				acc_q <= '0;
				if (in_acc) begin
					vv_q[0] <= coord_x;
					vv_q[1] <= coord_y;
					vv_q[2] <= coord_z;
					for (int k = 0; k < 3; k++) begin
						lo_q[k] <= center_q[k];
						hi_q[k] <= center_q[k];
					end
				end
			end
			S_ROT: begin
				case (phase_q)
					2'd0: prod_s1 <= mul_a * mul_b;
					2'd1: acc_q <= rot_acc_nx;
					default: begin
						acc_q <= '0;
						if (op.to_r) begin
							r_q[op.dst] <= r_new;
						end else begin
							t_q[op.dst] <= t_new;
						end
					end
				endcase
			end
			S_DOT_RD: acc_q <= '0;
			S_DOT_MUL: begin
				if (phase_q == 2'd0) begin
					prod_s1 <= mul_a * mul_b;
				end else begin
					acc_q <= dot_acc_nx;
					if (comp_q == 2'd2) begin
						dot_q <= chsq_pkg::DOT_W'(dot_acc_nx);
					end
				end
			end
			S_DOT_NEXT: begin
				if (idx_q == '0 || dot_q > best_q) begin
					best_q <= dot_q;
				end
			end
			S_MAG: begin
				mag_q <= chsq_pkg::MAG_W'(best_abs) + chsq_pkg::MAG_W'(chsq_pkg::ONE_Q16);
			end
			S_MPROD: begin
				mprod_q <= chsq_pkg::MPROD_W'(mag_q) * chsq_pkg::MPROD_W'(chsq_pkg::TIE_SCALE);
			end
			S_THRESH: begin
				thresh_q <= chsq_pkg::THR_W'(best_q) - chsq_pkg::THR_W'($signed({1'b0, margin}));
				for (int k = 0; k < 3; k++) begin
					sum_q[k] <= '0;
				end
				cnt_q <= '0;
			end
			S_TIE_ACC: begin
				if (tie) begin
					for (int k = 0; k < 3; k++) begin
						sum_q[k] <= sum_q[k] + chsq_pkg::SUM_W'(vr_q[k]);
					end
					cnt_q <= cnt_q + 6'd1;
				end
			end
			S_DIV_INIT: begin
				dq_q      <= sum_abs;
				sneg_q    <= sum_q[comp_q][chsq_pkg::SUM_W-1];
				rem_q     <= '0;
				divisor_q <= (cnt_q == '0) ? 6'd1 : cnt_q;
			end
			S_DIV: begin
				acc_q <= '0;
				rem_q <= rem_sub[5:0];
				dq_q  <= quot;
				if (bitc_q == 6'd1) begin
					vv_q[comp_q] <= sneg_q ? -CW'(quot) : CW'(quot);
				end
			end
			S_SUP_FIN: begin
				for (int k = 0; k < 3; k++) begin
					hi_q[k] <= world[k];
				end
			end
			S_BOX_LD: begin
				acc_q <= '0;
				for (int k = 0; k < 3; k++) begin
					vv_q[k] <= vr_q[k];
				end
			end
			S_BOX_WORLD: begin
				for (int k = 0; k < 3; k++) begin
					w_q[k] <= world[k];
				end
			end
			S_BOX_UPD: begin
				for (int k = 0; k < 3; k++) begin
					if (idx_q == '0 || w_q[k] < lo_q[k]) begin
						lo_q[k] <= w_q[k];
					end
					if (idx_q == '0 || w_q[k] > hi_q[k]) begin
						hi_q[k] <= w_q[k];
					end
				end
			end
			default: ;
		endcase

		if (out_load) begin
			if (state_q == S_EMIT_LO) begin
				pt_x_q <= lo_q[0];
				pt_y_q <= lo_q[1];
				pt_z_q <= lo_q[2];
				last_q <= 1'b0;
			end else begin
				pt_x_q <= hi_q[0];
				pt_y_q <= hi_q[1];
				pt_z_q <= hi_q[2];
				last_q <= 1'b1;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign point_x     = pt_x_q;
	assign point_y     = pt_y_q;
	assign point_z     = pt_z_q;
	assign last_result = last_q;

	`CHSQ_ASSERT_NEXT(a_box_hi_follows_lo, (state_q == S_EMIT_LO) && out_load, state_q == S_EMIT_HI, "box maximum must follow the minimum")
	`CHSQ_ASSERT_NEXT(a_support_starts_rot, in_acc && (kind == chsq_pkg::KIND_SUPPORT) && (n_cnt != '0), state_q == S_ROT, "support request must start with a rotation")
	`CHSQ_ASSERT_NOW(a_best_ties, state_q == S_DIV_INIT, cnt_q != '0, "best vertex must be counted as a tie")
	`CHSQ_ASSERT_NOW(a_scan_in_range, (state_q == S_DOT_RD) || (state_q == S_TIE_RD) || (state_q == S_BOX_RD), idx_q < n_cnt, "vertex scan index out of range")

endmodule

// ===== tb/convex_hull_support_query_top_tb.sv =====
`timescale 1ns / 1ps

module convex_hull_support_query_top_tb;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 20000;
	localparam int ITEM_TARGET = 850;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               last;
	} point_t;

	typedef struct {
		longint x;
		longint y;
		longint z;
	} vec_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               cfg_we = 1'b0;
	logic [chsq_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
	logic [chsq_pkg::COORD_W-1:0]       cfg_data = '0;
	logic                               in_valid = 1'b0;
	logic                               in_ready;
	logic [1:0]                         kind = chsq_pkg::KIND_LOAD;
	logic [4:0]                         slot = '0;
	logic signed [31:0]                 coord_x = '0;
	logic signed [31:0]                 coord_y = '0;
	logic signed [31:0]                 coord_z = '0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic signed [31:0]                 point_x;
	logic signed [31:0]                 point_y;
	logic signed [31:0]                 point_z;
	logic                               last_result;

	convex_hull_support_query_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .slot(slot), .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.point_x(point_x), .point_y(point_y), .point_z(point_z), .last_result(last_result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hull model state
	longint hull_cx, hull_cy, hull_cz;
	longint orient_w, orient_x, orient_y, orient_z;
	int     hull_count;
	longint vert_x[32], vert_y[32], vert_z[32];

	point_t expected_points[$];
	int     mismatches = 0;
	int     items_sent = 0;
	int     tx_idle_pct = 0;
	int     rx_idle_pct = 0;
	int     rx_hold = 0;
	int     stall_cycles = 0;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic vec_t quat_rotate(longint w, longint qx, longint qy, longint qz, vec_t v);
		longint t0, t1, t2;
		vec_t r;
		t0 = (qy * v.z - qz * v.y) >>> 13;
		t1 = (qz * v.x - qx * v.z) >>> 13;
		t2 = (qx * v.y - qy * v.x) >>> 13;
		r.x = clamp32(v.x + ((w * t0 + (qy * t2 - qz * t1)) >>> 14));
		r.y = clamp32(v.y + ((w * t1 + (qz * t0 - qx * t2)) >>> 14));
		r.z = clamp32(v.z + ((w * t2 + (qx * t1 - qy * t0)) >>> 14));
		return r;
	endfunction

	function automatic vec_t to_world(vec_t v);
		vec_t r;
		r = quat_rotate(orient_w, orient_x, orient_y, orient_z, v);
		r.x = clamp32(hull_cx + r.x);
		r.y = clamp32(hull_cy + r.y);
		r.z = clamp32(hull_cz + r.z);
		return r;
	endfunction

	function automatic void push_point(vec_t p, logic last);
		point_t e;
		e.x = p.x[31:0];
		e.y = p.y[31:0];
		e.z = p.z[31:0];
		e.last = last;
		expected_points.push_back(e);
	endfunction

	function automatic void predict_request(logic [1:0] k, logic [4:0] s,
			logic [31:0] x, logic [31:0] y, logic [31:0] z);
		int n, cnt;
		vec_t c, d, ld, v, lo, hi, avg;
		longint dots[32];
		longint best, sx, sy, sz;
		logic [63:0] mag, margin;
		n = (hull_count > 32) ? 32 : hull_count;
		c.x = hull_cx;
		c.y = hull_cy;
		c.z = hull_cz;
		case (k)
			chsq_pkg::KIND_LOAD: begin
				vert_x[s] = longint'($signed(x));
				vert_y[s] = longint'($signed(y));
				vert_z[s] = longint'($signed(z));
			end
			chsq_pkg::KIND_SUPPORT: begin
				if (n == 0) begin
					push_point(c, 1'b1);
				end else begin
					d.x = longint'($signed(x));
					d.y = longint'($signed(y));
					d.z = longint'($signed(z));
					ld = quat_rotate(orient_w, -orient_x, -orient_y, -orient_z, d);
					for (int i = 0; i < n; i++)
						dots[i] = ((vert_x[i] * ld.x) >>> 16) + ((vert_y[i] * ld.y) >>> 16)
							+ ((vert_z[i] * ld.z) >>> 16);
					best = dots[0];
					for (int i = 1; i < n; i++)
						if (dots[i] > best) best = dots[i];
					mag = 64'(best < 0 ? -best : best) + 64'd65536;
					margin = (mag * 64'd42950 + 64'hFFFF_FFFF) >> 32;
					sx = 0;
					sy = 0;
					sz = 0;
					cnt = 0;
					for (int i = 0; i < n; i++) begin
						if (dots[i] >= best - longint'(margin)) begin
							sx += vert_x[i];
							sy += vert_y[i];
							sz += vert_z[i];
							cnt++;
						end
					end
					if (cnt == 0) cnt = 1;
					avg.x = sx / cnt;
					avg.y = sy / cnt;
					avg.z = sz / cnt;
					push_point(to_world(avg), 1'b1);
				end
			end
			chsq_pkg::KIND_BOX: begin
				if (n == 0) begin
					push_point(c, 1'b0);
					push_point(c, 1'b1);
				end else begin
					v.x = vert_x[0];
					v.y = vert_y[0];
					v.z = vert_z[0];
					lo = to_world(v);
					hi = lo;
					for (int i = 1; i < n; i++) begin
						v.x = vert_x[i];
						v.y = vert_y[i];
						v.z = vert_z[i];
						v = to_world(v);
						if (v.x < lo.x) lo.x = v.x;
						if (v.y < lo.y) lo.y = v.y;
						if (v.z < lo.z) lo.z = v.z;
						if (v.x > hi.x) hi.x = v.x;
						if (v.y > hi.y) hi.y = v.y;
						if (v.z > hi.z) hi.z = v.z;
					end
					push_point(lo, 1'b0);
					push_point(hi, 1'b1);
				end
			end
			default: ;
		endcase
	endfunction

	// receiver: random stalls, long hold-off, result checking
	always @(posedge clk) begin
		point_t e;
		if (out_valid && out_ready) begin
			if (expected_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: %0d %0d %0d last=%0b",
						point_x, point_y, point_z, last_result);
			end else begin
				e = expected_points.pop_front();
				if (e.x !== point_x || e.y !== point_y || e.z !== point_z
						|| e.last !== last_result) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d %0d %0d last=%0b, got %0d %0d %0d last=%0b",
							e.x, e.y, e.z, e.last, point_x, point_y, point_z, last_result);
				end
			end
		end
		if (rx_hold > 0) begin
			rx_hold = rx_hold - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_req(input logic [1:0] k, input logic [4:0] s,
			input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		slot <= s;
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		do @(posedge clk); while (!in_ready);
		predict_request(k, s, x, y, z);
		items_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_points.size() != 0) @(posedge clk);
	endtask

	// registers change only with the block idle; a trailing load may still be in flight
	task automatic write_reg(input logic [chsq_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
		wait_drained();
		repeat (10) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			chsq_pkg::REG_CENTER_X:     hull_cx = longint'($signed(data));
			chsq_pkg::REG_CENTER_Y:     hull_cy = longint'($signed(data));
			chsq_pkg::REG_CENTER_Z:     hull_cz = longint'($signed(data));
			chsq_pkg::REG_QUAT_W:       orient_w = longint'($signed(data[15:0]));
			chsq_pkg::REG_QUAT_X:       orient_x = longint'($signed(data[15:0]));
			chsq_pkg::REG_QUAT_Y:       orient_y = longint'($signed(data[15:0]));
			chsq_pkg::REG_QUAT_Z:       orient_z = longint'($signed(data[15:0]));
			chsq_pkg::REG_VERTEX_COUNT: hull_count = int'(data[5:0]);
			default: ;
		endcase
	endtask

	// upper bits of the narrow registers are junk and must be dropped
	task automatic set_orientation(input int w, input int x, input int y, input int z);
		write_reg(chsq_pkg::REG_QUAT_W, {16'($urandom_range(65535)), w[15:0]});
		write_reg(chsq_pkg::REG_QUAT_X, {16'($urandom_range(65535)), x[15:0]});
		write_reg(chsq_pkg::REG_QUAT_Y, {16'($urandom_range(65535)), y[15:0]});
		write_reg(chsq_pkg::REG_QUAT_Z, {16'($urandom_range(65535)), z[15:0]});
	endtask

	task automatic set_count(input int n);
		write_reg(chsq_pkg::REG_VERTEX_COUNT, {26'($urandom_range(32'h3FF_FFFF)), n[5:0]});
	endtask

	function automatic logic [31:0] pick_coord(int style, int unit);
		case (style)
			0: return $urandom;
			1: return 32'($urandom_range(1 << 19) - (1 << 18));
			2: case ($urandom_range(2))
				0: return 32'(-unit);
				1: return 32'd0;
				default: return 32'(unit);
			endcase
			default: case ($urandom_range(3))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'd0;
				default: return 32'hFFFF_FFFF;
			endcase
		endcase
	endfunction

	task automatic random_pose();
		logic [31:0] c [3];
		for (int i = 0; i < 3; i++)
			c[i] = ($urandom_range(3) == 0) ? pick_coord(3, 0) : pick_coord($urandom_range(1), 0);
		write_reg(chsq_pkg::REG_CENTER_X, c[0]);
		write_reg(chsq_pkg::REG_CENTER_Y, c[1]);
		write_reg(chsq_pkg::REG_CENTER_Z, c[2]);
		case ($urandom_range(8))
			0: set_orientation(16384, 0, 0, 0);
			1: set_orientation(11585, 11585, 0, 0);
			2: set_orientation(11585, 0, -11585, 0);
			3: set_orientation(11585, 0, 0, 11585);
			4: set_orientation(0, 16384, 0, 0);
			5: set_orientation(8192, -8192, 8192, -8192);
			6: set_orientation(-16384, 0, 0, 0);
			7: set_orientation($urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
				$urandom_range(32768) - 16384, $urandom_range(32768) - 16384);
			default: set_orientation(14189, 0, 8192, 0);
		endcase
	endtask

	// one hull: optional new pose, count, vertices, then a burst of queries with some noise mixed in
	task automatic random_hull();
		int n, style, unit, nq, used;
		logic [31:0] d [3];
		if ($urandom_range(3) == 0) random_pose();
		case ($urandom_range(19))
			0:       n = 0;
			1:       n = 32;
			2:       n = $urandom_range(33, 63);
			default: n = $urandom_range(1, 8);
		endcase
		set_count(n);
		used = (n > 32) ? 32 : n;
		style = $urandom_range(3);
		unit = $urandom_range(1, 1 << 20);
		for (int i = 0; i < used; i++) begin
			if (i > 0 && $urandom_range(4) == 0)
				send_req(chsq_pkg::KIND_LOAD, 5'(i), 32'(vert_x[i-1]), 32'(vert_y[i-1]),
					32'(vert_z[i-1]));
			else
				send_req(chsq_pkg::KIND_LOAD, 5'(i), pick_coord(style, unit),
					pick_coord(style, unit), pick_coord(style, unit));
		end
		nq = $urandom_range(3, 8);
		for (int q = 0; q < nq; q++) begin
			case ($urandom_range(9))
				0: send_req(KIND_UNUSED, 5'($urandom), $urandom, $urandom, $urandom);
				1: send_req(chsq_pkg::KIND_BOX, 5'($urandom), $urandom, $urandom, $urandom);
				2: if (used < 32)
					send_req(chsq_pkg::KIND_LOAD, 5'($urandom_range(used, 31)), $urandom,
						$urandom, $urandom);
				default: begin
					if ($urandom_range(2) == 0) begin
						d[0] = 0;
						d[1] = 0;
						d[2] = 0;
						d[$urandom_range(2)] = $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000;
					end else begin
						for (int j = 0; j < 3; j++) d[j] = pick_coord($urandom_range(3), 1 << 16);
					end
					send_req(chsq_pkg::KIND_SUPPORT, 5'($urandom), d[0], d[1], d[2]);
				end
			endcase
		end
	endtask

	task automatic test_reset_state();
		send_req(chsq_pkg::KIND_SUPPORT, 5'd0, 32'h0001_0000, 32'd0, 32'd0);
		send_req(chsq_pkg::KIND_BOX, 5'd31, 32'd0, 32'd0, 32'd0);
		send_req(KIND_UNUSED, 5'd7, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		wait_drained();
	endtask

	task automatic test_directed_hull();
		write_reg(chsq_pkg::REG_CENTER_X, 32'h7FFF_FFFF);
		write_reg(chsq_pkg::REG_CENTER_Y, 32'h8000_0000);
		write_reg(chsq_pkg::REG_CENTER_Z, 32'h0001_0000);
		// vertices 0 and 1 share an x coordinate, but vertex 3 lies furthest along +x
		send_req(chsq_pkg::KIND_LOAD, 5'd0, 32'h0004_0000, 32'h0001_0000, 32'd0);
		send_req(chsq_pkg::KIND_LOAD, 5'd1, 32'h0004_0000, 32'hFFFF_0000, 32'd0);
		send_req(chsq_pkg::KIND_LOAD, 5'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_req(chsq_pkg::KIND_LOAD, 5'd3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
		send_req(chsq_pkg::KIND_LOAD, 5'd31, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
		set_count(4);
		send_req(chsq_pkg::KIND_SUPPORT, 5'd0, 32'h0001_0000, 32'd0, 32'd0);
		send_req(chsq_pkg::KIND_SUPPORT, 5'd0, 32'h0, 32'h0, 32'hFFFF_0000);
		send_req(chsq_pkg::KIND_SUPPORT, 5'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_req(chsq_pkg::KIND_BOX, 5'd0, 32'd0, 32'd0, 32'd0);
		write_reg(chsq_pkg::REG_CENTER_X, 32'd0);
		write_reg(chsq_pkg::REG_CENTER_Y, 32'd0);
		set_orientation(11585, 0, 0, 11585);
		send_req(chsq_pkg::KIND_SUPPORT, 5'd0, 32'h0001_0000, 32'h0001_0000, 32'd0);
		send_req(chsq_pkg::KIND_BOX, 5'd0, 32'd0, 32'd0, 32'd0);
		// unnormalised orientation saturates
		set_orientation(16384, 16384, -16384, 16384);
		send_req(chsq_pkg::KIND_SUPPORT, 5'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_req(chsq_pkg::KIND_BOX, 5'd0, 32'd0, 32'd0, 32'd0);
		wait_drained();
	endtask

	task automatic test_full_capacity();
		for (int i = 0; i < 32; i++)
			send_req(chsq_pkg::KIND_LOAD, 5'(i), pick_coord(1, 0), pick_coord(1, 0),
				pick_coord(1, 0));
		set_orientation(16384, 0, 0, 0);
		set_count(63);
		send_req(chsq_pkg::KIND_SUPPORT, 5'd0, $urandom, $urandom, $urandom);
		send_req(chsq_pkg::KIND_BOX, 5'd0, 32'd0, 32'd0, 32'd0);
		set_count(32);
		send_req(chsq_pkg::KIND_SUPPORT, 5'd0, 32'h0, 32'h0001_0000, 32'h0);
		wait_drained();
	endtask

	task automatic test_random_phase(input int tx_pct, input int rx_pct, input int target);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		while (items_sent < target) random_hull();
		wait_drained();
	endtask

	// receiver blocks for a long stretch while requests keep coming
	task automatic test_output_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_count(6);
		rx_hold = 3000;
		for (int i = 0; i < 12; i++)
			send_req((i % 3 == 0) ? chsq_pkg::KIND_BOX : chsq_pkg::KIND_SUPPORT, 5'd0,
				$urandom, $urandom, $urandom);
		wait_drained();
		for (int i = 0; i < 4; i++)
			send_req(chsq_pkg::KIND_SUPPORT, 5'd0, $urandom, $urandom, $urandom);
		wait_drained();
	endtask

	initial begin
		hull_cx = 0;
		hull_cy = 0;
		hull_cz = 0;
		orient_w = 16384;
		orient_x = 0;
		orient_y = 0;
		orient_z = 0;
		hull_count = 0;
		for (int i = 0; i < 32; i++) begin
			vert_x[i] = 0;
			vert_y[i] = 0;
			vert_z[i] = 0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_directed_hull();
		test_full_capacity();
		test_random_phase(20, 45, ITEM_TARGET / 3);
		test_random_phase(45, 20, 2 * ITEM_TARGET / 3);
		test_output_backpressure();
		test_random_phase(0, 0, ITEM_TARGET);

		wait_drained();
		repeat (1500) @(posedge clk);
		if (mismatches == 0 && expected_points.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
